[hw/rtl/fae_pkg.sv]
`timescale 1ns / 1ps

package fae_pkg;

	// Width of a Q24 factor as it travels between the multipliers.
	localparam int F_W = 48;
	// Width of a clamped factor magnitude (at most 2^46).
	localparam int MAG_W = 47;

	// Configuration port.
	localparam int IDX_W = 3;
	localparam int CFG_W = 60;

	localparam logic signed [F_W-1:0] Q24_ONE = 48'sd16777216;
	localparam logic signed [F_W-1:0] MAG_LIM = 48'sd70368744177664;

	// Output selection codes held in the mode register.
	localparam logic [2:0] MODE_PRODUCT = 3'd0;
	localparam logic [2:0] MODE_MASS1   = 3'd1;
	localparam logic [2:0] MODE_MASS2   = 3'd2;
	localparam logic [2:0] MODE_COS1    = 3'd3;
	localparam logic [2:0] MODE_COS2    = 3'd4;
	localparam logic [2:0] MODE_PHI     = 3'd5;
	localparam logic [2:0] MODE_TIME    = 3'd6;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_CHEB      = 3'd1;
	localparam logic [IDX_W-1:0] REG_SLOPE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_TURNON    = 3'd3;
	localparam logic [IDX_W-1:0] REG_LINEAR    = 3'd4;
	localparam logic [IDX_W-1:0] REG_QUADRATIC = 3'd5;

endpackage

[hw/rtl/fae_mul.sv]
`timescale 1ns / 1ps

module fae_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [fae_pkg::F_W-1:0]     a,
	input  logic signed [fae_pkg::F_W-1:0]     b,
	output logic signed [fae_pkg::F_W-1:0]     p
);
	import fae_pkg::*;

	localparam int HI_W = MAG_W - 24;

	// Clamp to magnitude 2^46 and take the absolute value.
	function automatic logic [MAG_W-1:0] clamp_abs(input logic signed [F_W-1:0] v);
		logic signed [F_W-1:0] nv;
		nv = -v;
		if (v > MAG_LIM || v < -MAG_LIM) begin
			clamp_abs = MAG_LIM[MAG_W-1:0];
		end else if (v < 0) begin
			clamp_abs = nv[MAG_W-1:0];
		end else begin
			clamp_abs = v[MAG_W-1:0];
		end
	endfunction

	logic [MAG_W-1:0] ua;
	logic [MAG_W-1:0] ub;

	logic [HI_W-1:0]   ah_s1, bh_s1;
	logic [23:0]       al_s1, bl_s1;
	logic              neg_s1;

	logic [2*HI_W-1:0] hh_s2;
	logic [HI_W+23:0]  hl_s2, lh_s2;
	logic [47:0]       ll_s2;
	logic              neg_s2;

	logic [49:0]       sum;
	logic [48:0]       ll_rnd;
	logic [49:0]       mag;
	logic signed [F_W-1:0] p_s3;

	assign ua = clamp_abs(a);
	assign ub = clamp_abs(b);

	// Split the magnitudes into high and low halves.
	always_ff @(posedge clk) begin
		if (en) begin
			ah_s1  <= ua[MAG_W-1:24];
			al_s1  <= ua[23:0];
			bh_s1  <= ub[MAG_W-1:24];
			bl_s1  <= ub[23:0];
			neg_s1 <= a[F_W-1] ^ b[F_W-1];
		end
	end

	// Partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s2  <= ah_s1 * bh_s1;
			hl_s2  <= ah_s1 * bl_s1;
			lh_s2  <= al_s1 * bh_s1;
			ll_s2  <= al_s1 * bl_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Recombine, round half up, saturate and apply the sign.
	always_comb begin
		ll_rnd = {1'b0, ll_s2} + 49'd8388608;
		sum = {hh_s2[25:0], 24'b0} + {3'b0, hl_s2} + {3'b0, lh_s2}
			+ {26'b0, ll_rnd[47:24]};
		if (hh_s2 >= 46'd4194304 || sum > {3'b0, MAG_LIM[MAG_W-1:0]}) begin
			mag = {3'b0, MAG_LIM[MAG_W-1:0]};
		end else begin
			mag = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= neg_s2 ? -$signed(mag[F_W-1:0]) : $signed(mag[F_W-1:0]);
		end
	end

	assign p = p_s3;

endmodule

[hw/rtl/factorized_acceptance_evaluator_core.sv]
// Throughput: one transaction per cycle; a two-entry output stage (register and skid)
// lets the input keep flowing while a result is stalled, and the 34-stage pipeline
// (25 of them the restoring divider of the time turn-on ratio) holds on a full skid.
// Reset (arst_n low) empties the pipeline and the output stage and loads the
// configuration registers with their reset values; datapath registers are not reset.
`timescale 1ns / 1ps

module factorized_acceptance_evaluator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fae_pkg::IDX_W-1:0]          cfg_index,
	input  logic [fae_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [15:0]                        mass_one,
	input  logic [15:0]                        mass_two,
	input  logic signed [15:0]                 cos_one,
	input  logic signed [15:0]                 cos_two,
	input  logic [15:0]                        decay_time,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [31:0]                 acceptance,
	output logic                               div_error
);
	import fae_pkg::*;

	localparam int LAST  = 34;
	localparam int T_W   = 41;
	localparam int ACC_W = 56;

	localparam logic signed [T_W-1:0] T0_ONE = 41'sd1073741824;
	localparam logic signed [F_W-1:0] ACC_MAX = 48'sd2147483647;
	localparam logic signed [F_W-1:0] ACC_MIN = -48'sd2147483648;

	// Chebyshev recurrence step: round(2*x*T(n)) - T(n-1), all in Q30.
	function automatic logic signed [T_W-1:0] cheb_next(
		input logic signed [15:0]    x,
		input logic signed [T_W-1:0] tc,
		input logic signed [T_W-1:0] tp
	);
		logic signed [56:0] pr;
		logic signed [56:0] sh;
		pr = x * tc;
		sh = (pr + 57'sd4096) >>> 13;
		cheb_next = sh[T_W-1:0] - tp;
	endfunction

	function automatic logic signed [ACC_W-1:0] cheb_term(
		input logic signed [11:0]    k,
		input logic signed [T_W-1:0] t
	);
		cheb_term = k * t;
	endfunction

	function automatic logic signed [F_W-1:0] cheb_round(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W-1:0] sh;
		sh = (s + 56'sd16384) >>> 15;
		cheb_round = Q24_ONE + sh[F_W-1:0];
	endfunction

	function automatic logic signed [F_W-1:0] mass_round(input logic signed [F_W-1:0] mp);
		logic signed [F_W-1:0] sh;
		sh = (mp + 48'sd2048) >>> 12;
		mass_round = Q24_ONE + sh;
	endfunction

	// Restoring divider step: {quotient bit, new remainder}.
	function automatic logic [53:0] div_step(input logic [52:0] rem, input logic [52:0] den);
		logic [53:0] r2;
		r2 = {rem, 1'b0};
		if (r2 >= {1'b0, den}) begin
			r2 = r2 - {1'b0, den};
			div_step = {1'b1, r2[52:0]};
		end else begin
			div_step = {1'b0, r2[52:0]};
		end
	endfunction

	// Configuration registers.
	logic [2:0]  mode_q;
	logic [59:0] cheb_q;
	logic [31:0] slope_q;
	logic [31:0] turnon_q;
	logic [31:0] lin_q;
	logic [31:0] quad_q;

	logic en;
	logic [LAST:1] vld_s;
	logic [LAST:1] zden_s;

	// Cosine lanes.
	logic signed [15:0]      cos_in [2];
	logic signed [11:0]      kc [1:5];
	logic signed [15:0]      cx_s [2][1:4];
	logic signed [T_W-1:0]   tc_s [2][1:5];
	logic signed [T_W-1:0]   tp_s [2][1:4];
	logic signed [ACC_W-1:0] acc_s [2][2:5];
	logic signed [ACC_W-1:0] csum_s6 [2];
	logic signed [F_W-1:0]   cf_s7 [2];

	// Mass factors.
	logic signed [F_W-1:0] mp1_s1, mp2_s1;
	logic signed [F_W-1:0] mf1_s [2:10];
	logic signed [F_W-1:0] mf2_s [2:13];

	// Time factor.
	logic [15:0]            d_s1;
	logic [31:0]            d2_s1;
	logic signed [F_W-1:0]  bd_s1, bd_s2;
	logic [47:0]            num_s2;
	logic signed [63:0]     cd2_s2;
	logic signed [F_W-1:0]  bd_rnd;
	logic signed [63:0]     cd_rnd;
	logic [52:0]            den_s [3:28];
	logic [52:0]            rem_s [3:28];
	logic [24:0]            q_s [3:28];
	logic [53:0]            dnext [4:28];
	logic signed [F_W-1:0]  poly_s [3:28];
	logic [25:0]            qp1;
	logic signed [F_W-1:0]  ratio;

	// Products and selected single factor.
	logic signed [F_W-1:0] single_sel;
	logic signed [F_W-1:0] single_s [8:LAST];
	logic signed [F_W-1:0] pa, pb, pc, pd, tf;
	logic signed [F_W-1:0] prod_s [17:31];
	logic signed [F_W-1:0] tf_s [32:LAST];

	// Output stage.
	logic signed [F_W-1:0] res_full;
	logic signed [31:0]    res_acc;
	logic                  res_err;
	logic                  out_valid_q, skid_valid_q;
	logic signed [31:0]    acc_q, skid_acc_q;
	logic                  err_q, skid_err_q;
	logic                  out_free;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PRODUCT;
			cheb_q   <= '0;
			slope_q  <= '0;
			turnon_q <= 32'd65536;
			lin_q    <= '0;
			quad_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q   <= cfg_data[2:0];
				REG_CHEB:      cheb_q   <= cfg_data[59:0];
				REG_SLOPE:     slope_q  <= cfg_data[31:0];
				REG_TURNON:    turnon_q <= cfg_data[31:0];
				REG_LINEAR:    lin_q    <= cfg_data[31:0];
				REG_QUADRATIC: quad_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the skid entry is occupied.
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	always_comb begin
		cos_in[0] = cos_one;
		cos_in[1] = cos_two;
		for (int i = 1; i <= 5; i++) begin
			kc[i] = $signed(cheb_q[12*(i-1) +: 12]);
		end
	end

	// Valid bits and the zero-denominator flag travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], in_valid};
		end
	end

	// Angular lanes: recurrence and running sum, one Chebyshev order per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				cx_s[l][1] <= cos_in[l];
				tc_s[l][1] <= {{9{cos_in[l][15]}}, cos_in[l], 16'b0};
				tp_s[l][1] <= T0_ONE;
				tc_s[l][2] <= cheb_next(cx_s[l][1], tc_s[l][1], tp_s[l][1]);
				acc_s[l][2] <= cheb_term(kc[1], tc_s[l][1]);
				for (int s = 2; s <= 4; s++) begin
					cx_s[l][s] <= cx_s[l][s-1];
					tp_s[l][s] <= tc_s[l][s-1];
				end
				for (int s = 3; s <= 5; s++) begin
					tc_s[l][s]  <= cheb_next(cx_s[l][s-1], tc_s[l][s-1], tp_s[l][s-1]);
					acc_s[l][s] <= acc_s[l][s-1] + cheb_term(kc[s-1], tc_s[l][s-1]);
				end
				csum_s6[l] <= acc_s[l][5] + cheb_term(kc[5], tc_s[l][5]);
				cf_s7[l]   <= cheb_round(csum_s6[l]);
			end
		end
	end

	// Mass factors, delayed to where the product chain takes them.
	always_ff @(posedge clk) begin
		if (en) begin
			mp1_s1   <= $signed(slope_q) * $signed({1'b0, mass_one});
			mp2_s1   <= $signed(slope_q) * $signed({1'b0, mass_two});
			mf1_s[2] <= mass_round(mp1_s1);
			mf2_s[2] <= mass_round(mp2_s1);
			for (int s = 3; s <= 10; s++) begin
				mf1_s[s] <= mf1_s[s-1];
			end
			for (int s = 3; s <= 13; s++) begin
				mf2_s[s] <= mf2_s[s-1];
			end
		end
	end

	// Time polynomial rounding terms.
	always_comb begin
		bd_rnd = (bd_s2 + 48'sd2048) >>> 12;
		cd_rnd = (cd2_s2 + 64'sd8388608) >>> 24;
	end

	always_comb begin
		for (int s = 4; s <= 28; s++) begin
			dnext[s] = div_step(rem_s[s-1], den_s[s-1]);
		end
	end

	// Time path: cube, denominator, 25 divider steps, polynomial alongside.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1      <= decay_time;
			d2_s1     <= decay_time * decay_time;
			bd_s1     <= $signed(lin_q) * $signed({1'b0, decay_time});
			zden_s[1] <= (turnon_q == 32'd0) && (decay_time == 16'd0);
			for (int s = 2; s <= LAST; s++) begin
				zden_s[s] <= zden_s[s-1];
			end
			num_s2    <= d2_s1 * d_s1;
			cd2_s2    <= $signed(quad_q) * $signed({1'b0, d2_s1});
			bd_s2     <= bd_s1;
			den_s[3]  <= {turnon_q, 20'b0} + {5'b0, num_s2};
			rem_s[3]  <= {5'b0, num_s2};
			q_s[3]    <= '0;
			poly_s[3] <= Q24_ONE + bd_rnd + cd_rnd[F_W-1:0];
			for (int s = 4; s <= 28; s++) begin
				den_s[s]  <= den_s[s-1];
				rem_s[s]  <= dnext[s][52:0];
				q_s[s]    <= {q_s[s-1][23:0], dnext[s][53]};
				poly_s[s] <= poly_s[s-1];
			end
		end
	end

	// Ratio rounded half up from the 25-bit quotient.
	assign qp1   = {1'b0, q_s[28]} + 26'd1;
	assign ratio = $signed({23'b0, qp1[25:1]});

	fae_mul u_mul_time (.clk(clk), .en(en), .a(ratio), .b(poly_s[28]), .p(tf));

	// Product chain: cos1, cos2, mass1, mass2, then time.
	fae_mul u_mul_cos  (.clk(clk), .en(en), .a(cf_s7[0]), .b(cf_s7[1]), .p(pa));
	fae_mul u_mul_m1   (.clk(clk), .en(en), .a(pa), .b(mf1_s[10]), .p(pb));
	fae_mul u_mul_m2   (.clk(clk), .en(en), .a(pb), .b(mf2_s[13]), .p(pc));
	fae_mul u_mul_tf   (.clk(clk), .en(en), .a(prod_s[31]), .b(tf), .p(pd));

	// Single-factor selection for the modes that show one factor.
	always_comb begin
		case (mode_q)
			MODE_MASS1: single_sel = mf1_s[7];
			MODE_MASS2: single_sel = mf2_s[7];
			MODE_COS1:  single_sel = cf_s7[0];
			MODE_COS2:  single_sel = cf_s7[1];
			MODE_PHI:   single_sel = Q24_ONE;
			default:    single_sel = '0;
		endcase
	end

	// Delay lines to the last stage.
	always_ff @(posedge clk) begin
		if (en) begin
			single_s[8] <= single_sel;
			for (int s = 9; s <= LAST; s++) begin
				single_s[s] <= single_s[s-1];
			end
			prod_s[17] <= pc;
			for (int s = 18; s <= 31; s++) begin
				prod_s[s] <= prod_s[s-1];
			end
			tf_s[32] <= tf;
			for (int s = 33; s <= LAST; s++) begin
				tf_s[s] <= tf_s[s-1];
			end
		end
	end

	// Final selection and saturation to Q8.24.
	always_comb begin
		res_err = zden_s[LAST] && (mode_q == MODE_PRODUCT || mode_q == MODE_TIME);
		case (mode_q)
			MODE_PRODUCT: res_full = zden_s[LAST] ? '0 : pd;
			MODE_TIME:    res_full = zden_s[LAST] ? '0 : tf_s[LAST];
			default:      res_full = single_s[LAST];
		endcase
		if (res_full > ACC_MAX) begin
			res_acc = 32'sh7FFFFFFF;
		end else if (res_full < ACC_MIN) begin
			res_acc = 32'sh80000000;
		end else begin
			res_acc = res_full[31:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= vld_s[LAST];
		end else if (vld_s[LAST]) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				acc_q <= skid_acc_q;
				err_q <= skid_err_q;
			end
		end else if (out_free) begin
			acc_q <= res_acc;
			err_q <= res_err;
		end else begin
			skid_acc_q <= res_acc;
			skid_err_q <= res_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign acceptance = acc_q;
	assign div_error  = err_q;

`ifndef NO_ASSERTIONS
	// The skid entry is only ever occupied behind a held output transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry occupied without an output transaction");

	// The skid entry fills only when the output was stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled while the output was free");

	// With the skid empty and the output free, the last stage moves straight out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_valid_q && out_free) |=> (out_valid_q == $past(vld_s[LAST])))
		else $error("last pipeline stage not transferred to the output");

	// In the product and time modes, a zero time denominator gives a zero weight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && div_error) |-> (acceptance == 32'sd0))
		else $error("non-zero weight reported with a division error");
`endif

endmodule
